>>> rtl/dasd_pkg.sv
// Shared types and constants for the door angle snap detector.
package dasd_pkg;

  // Motion classes reported on the result channel.
  typedef enum logic [1:0] {
    MOTION_CLOSING = 2'd0,
    MOTION_OPENING = 2'd1,
    MOTION_NONE    = 2'd2
  } motion_e;

  // Register indexes (byte address = 4 * index).
  localparam logic [1:0] REG_OPEN  = 2'd0;
  localparam logic [1:0] REG_CLOSE = 2'd1;
  localparam logic [1:0] REG_SNAP  = 2'd2;

  localparam int CfgW       = 9;    // whole-degree register width
  localparam int FullTurn   = 360;  // degrees
  localparam int NoiseDeg   = 20;   // largest accepted distance, degrees
  localparam int RangeLow   = 20;   // narrowest open/close spread
  localparam int RangeHigh  = 120;  // widest open/close spread

  // Turn direction derived from the open and close angles.
  typedef struct packed {
    logic cw;   // door turns clockwise while closing
    logic bad;  // open/close setup is impossible
  } dir_t;

endpackage

>>> rtl/door_angle_snap_detector.sv
// Top level of the door angle snap detector.
//
// Takes one compass heading request per cycle (1/16 degree units) and returns
// exactly one result per request: noise flag, four-sample average in 1/64
// degree (unwrapped), motion class, armed state, opened event, snap pulse and
// setup check. The open and close angles set the turn direction; headings
// below the working range get a full turn added. The first heading after
// reset fills the four-entry ring. A heading 21 degrees or more from the
// current average is dropped and changes nothing. Opening past the open angle
// arms the block, passing the close angle disarms it, and closing past the
// snap angle while armed raises snap_pulse_o for that result and disarms.
// Timing: a request is held in the input register, is evaluated in one pass
// of compare/add logic and lands in the result register, and one request per
// cycle is sustained while results are taken; the single state update per
// cycle (ring, average, history, armed) sets that rate. Under output stall
// both registers hold: an empty input register still takes a request, and
// once it holds a request behind a waiting result, in_ready_o stays low until
// that result is taken. Angle registers must be written over the APB port
// only while no requests are in flight; the block does not enforce this;
// open at 0x0, close at 0x4, snap at 0x8, whole degrees in bits 8:0.
module door_angle_snap_detector #(
  parameter int ANGLE_FRAC_BITS = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // heading requests
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ANGLE_FRAC_BITS+8:0] heading_sample_i,
  // results
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       noise_dropped_o,
  output logic [15:0]                average_angle_o,
  output logic [1:0]                 motion_class_o,
  output logic                       armed_flag_o,
  output logic                       opened_event_o,
  output logic                       snap_pulse_o,
  output logic                       setup_invalid_o,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int SampW = ANGLE_FRAC_BITS + 9;   // raw heading
  localparam int UnwW  = SampW + 1;             // unwrapped heading
  localparam int AvgW  = SampW + 3;             // ring sum, 1/64 degree at 4 frac bits
  localparam int CfgW  = dasd_pkg::CfgW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0] open_q, close_q, snap_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= '0;
      close_q <= '0;
      snap_q  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        dasd_pkg::REG_OPEN:  open_q  <= pwdata[CfgW-1:0];
        dasd_pkg::REG_CLOSE: close_q <= pwdata[CfgW-1:0];
        dasd_pkg::REG_SNAP:  snap_q  <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      dasd_pkg::REG_OPEN:  prdata = 32'(open_q);
      dasd_pkg::REG_CLOSE: prdata = 32'(close_q);
      dasd_pkg::REG_SNAP:  prdata = 32'(snap_q);
      default:             prdata = '0;
    endcase
  end

  dasd_pkg::dir_t dir;

  dasd_dir u_dir (
    .open_angle_i  (open_q),
    .close_angle_i (close_q),
    .dir_o         (dir)
  );

  // ---------------------------------------------------------------------------
  // Pipeline control: input register -> result register
  // ---------------------------------------------------------------------------
  logic             s1_valid_q;
  logic [SampW-1:0] s1_sample_q;
  logic             out_valid_q;
  logic             advance;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) s1_sample_q <= heading_sample_i;
  end

  // ---------------------------------------------------------------------------
  // Filter state
  // ---------------------------------------------------------------------------
  logic [UnwW-1:0]   ring_q [4];
  logic [1:0]        ptr_q;
  logic              primed_q;
  logic [AvgW-1:0]   avg_q;
  logic [AvgW-1:0]   hist_q [4];
  dasd_pkg::motion_e motion_q;
  logic              armed_q;

  // unwrap below the working range
  logic [UnwW-1:0] lower_fx, samp;
  logic [CfgW-1:0] lower;

  always_comb begin
    lower    = dir.cw ? open_q : close_q;
    lower_fx = UnwW'(lower) << ANGLE_FRAC_BITS;
    samp     = UnwW'(s1_sample_q);
    if (samp < lower_fx) samp = samp + (UnwW'(dasd_pkg::FullTurn) << ANGLE_FRAC_BITS);
  end

  // the first heading acts as a ring already full of itself
  logic [AvgW-1:0] avg_eff, samp4, distance, new_avg;
  logic [UnwW-1:0] ring_old;
  logic [1:0]      ptr_eff;
  logic            drop;

  always_comb begin
    samp4    = AvgW'(samp) << 2;
    avg_eff  = primed_q ? avg_q : samp4;
    ptr_eff  = primed_q ? ptr_q : 2'd0;
    ring_old = primed_q ? ring_q[ptr_q] : samp;
    distance = (avg_eff > samp4) ? (avg_eff - samp4) : (samp4 - avg_eff);
    drop     = distance >= (AvgW'(dasd_pkg::NoiseDeg + 1) << (ANGLE_FRAC_BITS + 2));
    new_avg  = avg_eff - AvgW'(ring_old) + AvgW'(samp);
  end

  logic [AvgW-1:0]   hist_n [4];
  dasd_pkg::motion_e motion_n;

  always_comb begin
    hist_n[0] = new_avg;
    hist_n[1] = hist_q[0];
    hist_n[2] = hist_q[1];
    hist_n[3] = hist_q[2];
  end

  dasd_trend #(
    .AvgW (AvgW)
  ) u_trend (
    .hist_i   (hist_n),
    .cw_i     (dir.cw),
    .motion_o (motion_n)
  );

  // arm / disarm / snap
  logic [AvgW-1:0] op_fx, cl_fx, sn_fx;
  logic            past_open, past_close, past_snap;
  logic            armed_n, opened_n, snap_n;

  always_comb begin
    op_fx      = AvgW'(open_q)  << (ANGLE_FRAC_BITS + 2);
    cl_fx      = AvgW'(close_q) << (ANGLE_FRAC_BITS + 2);
    sn_fx      = AvgW'(snap_q)  << (ANGLE_FRAC_BITS + 2);
    past_open  = dir.cw ? (new_avg < op_fx) : (new_avg > op_fx);
    past_close = dir.cw ? (new_avg > cl_fx) : (new_avg < cl_fx);
    past_snap  = dir.cw ? (new_avg > sn_fx) : (new_avg < sn_fx);
    armed_n    = armed_q;
    opened_n   = 1'b0;
    snap_n     = 1'b0;
    if (past_open && motion_n == dasd_pkg::MOTION_OPENING) begin
      armed_n  = 1'b1;
      opened_n = 1'b1;
    end
    if (past_close) armed_n = 1'b0;
    if (past_snap && motion_n == dasd_pkg::MOTION_CLOSING && armed_n) begin
      armed_n = 1'b0;
      snap_n  = 1'b1;
    end
  end

  logic update;
  assign update = advance && !drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        ring_q[i] <= '0;
        hist_q[i] <= '0;
      end
      ptr_q    <= '0;
      primed_q <= 1'b0;
      avg_q    <= '0;
      motion_q <= dasd_pkg::MOTION_CLOSING;
      armed_q  <= 1'b0;
    end else if (update) begin
      for (int i = 0; i < 4; i++) begin
        if (!primed_q || ptr_eff == 2'(i)) ring_q[i] <= samp;
        hist_q[i] <= hist_n[i];
      end
      ptr_q    <= ptr_eff + 2'd1;
      primed_q <= 1'b1;
      avg_q    <= new_avg;
      motion_q <= motion_n;
      armed_q  <= armed_n;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic            res_drop_q, res_armed_q, res_open_q, res_snap_q, res_bad_q;
  logic [AvgW-1:0] res_avg_q;
  logic [1:0]      res_motion_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_drop_q   <= drop;
      res_avg_q    <= drop ? avg_q : new_avg;
      res_motion_q <= drop ? motion_q : motion_n;
      res_armed_q  <= drop ? armed_q : armed_n;
      res_open_q   <= !drop && opened_n;
      res_snap_q   <= !drop && snap_n;
      res_bad_q    <= dir.bad;
    end
  end

  assign noise_dropped_o = res_drop_q;
  assign average_angle_o = 16'(res_avg_q);
  assign motion_class_o  = res_motion_q;
  assign armed_flag_o    = res_armed_q;
  assign opened_event_o  = res_open_q;
  assign snap_pulse_o    = res_snap_q;
  assign setup_invalid_o = res_bad_q;

endmodule

>>> rtl/dasd_dir.sv
// Turn direction and setup check from the open and close angles.
module dasd_dir (
  input  logic [dasd_pkg::CfgW-1:0] open_angle_i,
  input  logic [dasd_pkg::CfgW-1:0] close_angle_i,
  output dasd_pkg::dir_t            dir_o
);

  logic signed [11:0] o_s, c_s, d_s, ad_s;

  always_comb begin
    o_s  = 12'(signed'({1'b0, open_angle_i}));
    c_s  = 12'(signed'({1'b0, close_angle_i}));
    d_s  = c_s - o_s;
    ad_s = (d_s < 0) ? -d_s : d_s;
    dir_o.cw  = 1'b0;
    dir_o.bad = 1'b0;
    if (ad_s < 12'(dasd_pkg::RangeLow)) begin
      dir_o.bad = 1'b1;
    end else if (ad_s > 12'(dasd_pkg::RangeHigh)) begin
      // spread wraps through north
      if (c_s > o_s) begin
        dir_o.bad = (o_s + 12'(dasd_pkg::FullTurn) - c_s) > 12'(dasd_pkg::RangeHigh);
      end else if ((c_s + 12'(dasd_pkg::FullTurn) - o_s) > 12'(dasd_pkg::RangeHigh)) begin
        dir_o.bad = 1'b1;
      end else begin
        dir_o.cw = 1'b1;
      end
    end else begin
      dir_o.cw = c_s > o_s;
    end
  end

endmodule

>>> rtl/dasd_trend.sv
// Motion class from four successive averages.
module dasd_trend #(
  parameter int AvgW = 16
) (
  input  logic [AvgW-1:0]  hist_i [4],  // newest first
  input  logic             cw_i,
  output dasd_pkg::motion_e motion_o
);

  logic rising, falling;

  always_comb begin
    rising  = (hist_i[0] > hist_i[1]) && (hist_i[1] > hist_i[2]) && (hist_i[2] > hist_i[3]);
    falling = (hist_i[0] < hist_i[1]) && (hist_i[1] < hist_i[2]) && (hist_i[2] < hist_i[3]);
    if (rising) begin
      motion_o = cw_i ? dasd_pkg::MOTION_CLOSING : dasd_pkg::MOTION_OPENING;
    end else if (falling) begin
      motion_o = cw_i ? dasd_pkg::MOTION_OPENING : dasd_pkg::MOTION_CLOSING;
    end else begin
      motion_o = dasd_pkg::MOTION_NONE;
    end
  end

endmodule
